[rtl/ssm_pkg.sv]
// Shared types and constants for the subset-sum maximizer.
`default_nettype none

package ssm_pkg;

  // Default sizing
  localparam int unsigned SUM_LIMIT_DEF = 1023;
  localparam int unsigned MAX_ITEMS_DEF = 32;

  // Fixed field widths
  localparam int unsigned ValW = 10;

  // Reset value of the capacity register
  localparam logic [ValW-1:0] CAP_RESET = 10'd1023;

  // Result word kinds
  localparam logic KIND_SUM   = 1'b0;
  localparam logic KIND_INDEX = 1'b1;

  // Input word
  typedef struct packed {
    logic [ValW-1:0] item_value;
    logic            last_item;
  } ssm_in_t;

  // Result word
  typedef struct packed {
    logic            kind;
    logic [ValW-1:0] result_value;
    logic            last;
  } ssm_out_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,   // sweep the reachable-sum map back to "only zero"
    ST_IDLE,    // wait for an item
    ST_SCAN,    // one sum per cycle, high to low
    ST_DRAIN,   // finish the last pending map update
    ST_SRCH,    // look for the largest reachable sum
    ST_TR_FRI,  // trace: read first-reaching item of current sum
    ST_TR_VAL,  // trace: read stored value of that item
    ST_TR_CHK,  // trace: check, subtract and emit
    ST_TR_END   // emit the final word of the run
  } ssm_state_e;

endpackage

`default_nettype wire

[rtl/subset_sum_max_with_selection.sv]
// Subset-sum maximizer: top level with sequencer, map memories and output register.
`default_nettype none

// Items stream in one word at a time and are folded into a 0/1 reachable-sum
// map over 0..min(capacity, SUM_LIMIT). A plain item is accepted and then
// scanned into the map from high sums to low, one sum per cycle through the
// single write port of the map memory; an item that is zero, too large, or
// beyond MAX_ITEMS is accepted without a scan. The item marked last then
// adds a downward search for the best sum, a trace back over the selected
// indices, and a clearing pass over the map (also run once after reset). The
// input is not ready while any of this is in progress. The first result
// word carries the best sum, then the 1-based item indices follow in
// decreasing order; the final word of a run has last set.
module subset_sum_max_with_selection
  import ssm_pkg::*;
#(
  parameter int unsigned SUM_LIMIT = SUM_LIMIT_DEF,
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  // input words
  input  wire logic            in_valid_i,
  output      logic            in_ready_o,
  input  wire ssm_in_t         in_word_i,
  // result words
  output      logic            out_valid_o,
  input  wire logic            out_ready_i,
  output      ssm_out_t        out_word_o,
  // capacity register
  input  wire logic            cfg_we_i,
  input  wire logic [ValW-1:0] cfg_data_i
);

  localparam int unsigned SumW  = $clog2(SUM_LIMIT + 1);
  localparam int unsigned WideW = (SumW > ValW) ? SumW : ValW;
  localparam int unsigned IdxW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_ITEMS + 1);
  localparam logic [SumW-1:0]  SumTop   = SumW'(SUM_LIMIT);
  localparam logic [WideW-1:0] SumTopW  = WideW'(SUM_LIMIT);
  localparam logic [CntW-1:0]  ItemsTop = CntW'(MAX_ITEMS);
  localparam logic [IdxW:0]    ItemsTopX = (IdxW+1)'(MAX_ITEMS);

  // Memories
  logic            reach_mem [SUM_LIMIT+1];
  logic [IdxW-1:0] fri_mem   [SUM_LIMIT+1];
  logic [ValW-1:0] val_mem   [MAX_ITEMS];

  // Control registers
  ssm_state_e      state_q, state_d;
  logic [SumW-1:0] ptr_q, ptr_d;
  logic            pipe_vld_q, pipe_vld_d;
  logic [CntW-1:0] taken_q, taken_d;
  logic [CntW-1:0] steps_q, steps_d;
  logic            out_valid_q, out_valid_d;
  logic [ValW-1:0] cap_q;

  // Payload registers
  logic [ValW-1:0] val_q, val_d;
  logic            last_q, last_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [SumW-1:0] pipe_addr_q, pipe_addr_d;
  logic            pend_kind_q, pend_kind_d;
  logic [ValW-1:0] pend_val_q, pend_val_d;
  ssm_out_t        out_word_q, out_word_d;

  // Memory read data
  logic            rd_a_q, rd_b_q;
  logic [IdxW-1:0] fri_rd_q;
  logic [ValW-1:0] val_rd_q;

  // Memory controls
  logic            reach_we, reach_wdata;
  logic [SumW-1:0] reach_waddr;
  logic [SumW-1:0] raddr_a, raddr_b;
  logic            fri_we, fri_re, val_we, val_re;

  // Shared decode
  logic [WideW-1:0] cap_wide;
  logic [SumW-1:0]  bound;
  logic [SumW-1:0]  in_val_s, val_s;
  logic             acc_in, take, fit, srch_hit, out_free, upd;
  logic             tr_stop_a, tr_stop_b, tr_stop_c;

  assign cap_wide = WideW'(cap_q);
  assign bound    = (cap_wide < SumTopW) ? cap_wide[SumW-1:0] : SumTop;
  assign in_val_s = SumW'(in_word_i.item_value);
  assign val_s    = SumW'(val_q);

  assign acc_in   = in_valid_i && (state_q == ST_IDLE);
  assign take     = (taken_q < ItemsTop);
  assign fit      = (in_word_i.item_value != '0) &&
                    (WideW'(in_word_i.item_value) <= WideW'(bound));
  assign srch_hit = pipe_vld_q && rd_a_q;
  assign out_free = !out_valid_q || out_ready_i;
  // map update: lower sum reachable, upper not yet
  assign upd      = pipe_vld_q && rd_a_q && !rd_b_q &&
                    ((state_q == ST_SCAN) || (state_q == ST_DRAIN));

  // trace stop conditions
  assign tr_stop_a = (sum_q == '0) || (steps_q == ItemsTop);
  assign tr_stop_b = ({1'b0, fri_rd_q} >= ItemsTopX);
  assign tr_stop_c = (val_rd_q == '0) || (WideW'(val_rd_q) > WideW'(sum_q));

  assign raddr_a = ptr_q;
  assign raddr_b = ptr_q + val_s;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (ptr_q == SumTop) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc_in) begin
          if (take && fit) state_d = ST_SCAN;
          else if (in_word_i.last_item) state_d = ST_SRCH;
        end
      end
      ST_SCAN: begin
        if (ptr_q == '0) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = last_q ? ST_SRCH : ST_IDLE;
      end
      ST_SRCH: begin
        if (srch_hit) state_d = ST_TR_FRI;
      end
      ST_TR_FRI: begin
        state_d = tr_stop_a ? ST_TR_END : ST_TR_VAL;
      end
      ST_TR_VAL: begin
        state_d = tr_stop_b ? ST_TR_END : ST_TR_CHK;
      end
      ST_TR_CHK: begin
        if (tr_stop_c) state_d = ST_TR_END;
        else if (out_free) state_d = ST_TR_FRI;
      end
      ST_TR_END: begin
        if (out_free) state_d = ST_CLEAR;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    ptr_d       = ptr_q;
    pipe_vld_d  = 1'b0;
    pipe_addr_d = pipe_addr_q;
    taken_d     = taken_q;
    steps_d     = steps_q;
    val_d       = val_q;
    last_d      = last_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    pend_kind_d = pend_kind_q;
    pend_val_d  = pend_val_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;
    reach_we    = 1'b0;
    reach_waddr = pipe_addr_q;
    reach_wdata = 1'b1;
    fri_we      = 1'b0;
    fri_re      = 1'b0;
    val_we      = 1'b0;
    val_re      = 1'b0;

    // pending map update from the previous scan read
    if (upd) begin
      reach_we = 1'b1;
      fri_we   = 1'b1;
    end

    unique case (state_q)
      ST_CLEAR: begin
        reach_we    = 1'b1;
        reach_waddr = ptr_q;
        reach_wdata = (ptr_q == '0);
        ptr_d       = ptr_q + 1'b1;
        if (ptr_q == SumTop) begin
          taken_d = '0;
        end
      end
      ST_IDLE: begin
        if (acc_in) begin
          val_d  = in_word_i.item_value;
          last_d = in_word_i.last_item;
          idx_d  = taken_q[IdxW-1:0];
          if (take) begin
            val_we  = 1'b1;
            taken_d = taken_q + 1'b1;
          end
          if (take && fit) ptr_d = bound - in_val_s;
          else ptr_d = bound;
        end
      end
      ST_SCAN: begin
        pipe_vld_d  = 1'b1;
        pipe_addr_d = raddr_b;
        if (ptr_q != '0) ptr_d = ptr_q - 1'b1;
      end
      ST_DRAIN: begin
        ptr_d = bound;
      end
      ST_SRCH: begin
        if (srch_hit) begin
          sum_d       = pipe_addr_q;
          steps_d     = '0;
          pend_kind_d = KIND_SUM;
          pend_val_d  = ValW'(pipe_addr_q);
        end else begin
          pipe_vld_d  = 1'b1;
          pipe_addr_d = ptr_q;
          if (ptr_q != '0) ptr_d = ptr_q - 1'b1;
        end
      end
      ST_TR_FRI: begin
        fri_re = !tr_stop_a;
      end
      ST_TR_VAL: begin
        val_re = !tr_stop_b;
        idx_d  = fri_rd_q;
      end
      ST_TR_CHK: begin
        if (!tr_stop_c && out_free) begin
          out_valid_d = 1'b1;
          out_word_d  = '{kind: pend_kind_q, result_value: pend_val_q, last: 1'b0};
          pend_kind_d = KIND_INDEX;
          pend_val_d  = ValW'(idx_q) + 1'b1;
          sum_d       = sum_q - SumW'(val_rd_q);
          steps_d     = steps_q + 1'b1;
        end
      end
      ST_TR_END: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_word_d  = '{kind: pend_kind_q, result_value: pend_val_q, last: 1'b1};
          ptr_d       = '0;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ptr_q       <= '0;
      pipe_vld_q  <= 1'b0;
      taken_q     <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
      cap_q       <= CAP_RESET;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      pipe_vld_q  <= pipe_vld_d;
      taken_q     <= taken_d;
      steps_q     <= steps_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) cap_q <= cfg_data_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    last_q      <= last_d;
    idx_q       <= idx_d;
    sum_q       <= sum_d;
    pipe_addr_q <= pipe_addr_d;
    pend_kind_q <= pend_kind_d;
    pend_val_q  <= pend_val_d;
    out_word_q  <= out_word_d;
  end

  // Reachable-sum map: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (reach_we) reach_mem[reach_waddr] <= reach_wdata;
    rd_a_q <= reach_mem[raddr_a];
    rd_b_q <= reach_mem[raddr_b];
  end

  // First-reaching item per sum
  always_ff @(posedge clk_i) begin
    if (fri_we) fri_mem[pipe_addr_q] <= idx_q;
    if (fri_re) fri_rd_q <= fri_mem[sum_q];
  end

  // Stored item values
  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[taken_q[IdxW-1:0]] <= in_word_i.item_value;
    if (val_re) val_rd_q <= val_mem[fri_rd_q];
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

[rtl/ssm_checker.sv]
// Port-level checks for the subset-sum maximizer, bound to its top level.
`default_nettype none

module ssm_checker
  import ssm_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
) (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_ready_o,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire ssm_out_t out_word_o
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // A zero best sum ends the run on its own
  a_zero_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.kind == KIND_SUM) && (out_word_o.result_value == '0)
      |-> out_word_o.last)
    else $error("zero sum word not marked last");

  // Item indices are 1-based and within the item limit
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.kind == KIND_INDEX)
      |-> (out_word_o.result_value != '0) &&
          (out_word_o.result_value <= ValW'(MAX_ITEMS)))
    else $error("item index out of range");

  // No new item is taken in the middle of a result run
  a_no_accept_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.last |-> !in_ready_o)
    else $error("input ready during a result run");

endmodule

bind subset_sum_max_with_selection ssm_checker #(
  .MAX_ITEMS (MAX_ITEMS)
) u_ssm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire

[tb/sv/subset_sum_max_with_selection_tb.sv]
// Self-checking testbench for the subset-sum maximizer: directed table plus random sets.
`default_nettype none

module subset_sum_max_with_selection_tb;
  import ssm_pkg::*;

  // Timing budget for waits on the block's map scans and clearing passes
  localparam int unsigned SETTLE_CYCLES = 2 * (SUM_LIMIT_DEF + 1) + 64;
  localparam int unsigned STALL_LIMIT   = 20000;
  localparam int unsigned HOLD_CYCLES   = 3000;
  localparam int unsigned HOLD_AFTER    = 40;
  localparam int unsigned RANDOM_ITEMS  = 430;
  localparam int unsigned QUIET_AFTER   = 370;

  // Directed stimulus table
  typedef enum logic {ROW_ITEM, ROW_CAP} row_op_e;

  typedef struct packed {
    row_op_e         op;
    logic [ValW-1:0] value;
    logic            last;
    logic            typed;     // expected words typed in below
    logic [ValW-1:0] exp_sum;
    logic [ValW-1:0] exp_idx;   // 0: the sum word is the only word
  } row_t;

  localparam int DIR_ROWS = 22;
  localparam row_t DIR_TABLE [DIR_ROWS] = '{
    // reset capacity: one full-scale item fills the whole range
    '{ROW_ITEM, 10'd1023, 1'b1, 1'b1, 10'd1023, 10'd1},
    // zero item alone: optimum zero
    '{ROW_ITEM, 10'd0,    1'b1, 1'b1, 10'd0,    10'd0},
    '{ROW_ITEM, 10'd1,    1'b1, 1'b1, 10'd1,    10'd1},
    // capacity zero: nothing fits
    '{ROW_CAP,  10'd0,    1'b0, 1'b0, 10'd0,    10'd0},
    '{ROW_ITEM, 10'd5,    1'b1, 1'b1, 10'd0,    10'd0},
    '{ROW_ITEM, 10'd0,    1'b1, 1'b1, 10'd0,    10'd0},
    // small capacity, mixed set
    '{ROW_CAP,  10'd10,   1'b0, 1'b0, 10'd0,    10'd0},
    '{ROW_ITEM, 10'd3,    1'b0, 1'b0, 10'd0,    10'd0},
    '{ROW_ITEM, 10'd4,    1'b0, 1'b0, 10'd0,    10'd0},
    '{ROW_ITEM, 10'd7,    1'b0, 1'b0, 10'd0,    10'd0},
    '{ROW_ITEM, 10'd6,    1'b1, 1'b0, 10'd0,    10'd0},
    // item over capacity is skipped
    '{ROW_ITEM, 10'd11,   1'b0, 1'b0, 10'd0,    10'd0},
    '{ROW_ITEM, 10'd10,   1'b1, 1'b1, 10'd10,   10'd2},
    // zero items around a real one
    '{ROW_ITEM, 10'd0,    1'b0, 1'b0, 10'd0,    10'd0},
    '{ROW_ITEM, 10'd5,    1'b0, 1'b0, 10'd0,    10'd0},
    '{ROW_ITEM, 10'd0,    1'b1, 1'b0, 10'd0,    10'd0},
    // capacity lowered in the middle of a set
    '{ROW_CAP,  10'd1023, 1'b0, 1'b0, 10'd0,    10'd0},
    '{ROW_ITEM, 10'd600,  1'b0, 1'b0, 10'd0,    10'd0},
    '{ROW_CAP,  10'd500,  1'b0, 1'b0, 10'd0,    10'd0},
    '{ROW_ITEM, 10'd300,  1'b1, 1'b0, 10'd0,    10'd0},
    '{ROW_ITEM, 10'd512,  1'b0, 1'b0, 10'd0,    10'd0},
    '{ROW_ITEM, 10'd511,  1'b1, 1'b0, 10'd0,    10'd0}
  };

  // DUT ports
  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  ssm_in_t         in_word_i   = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  ssm_out_t        out_word_o;
  logic            cfg_we_i    = 1'b0;
  logic [ValW-1:0] cfg_data_i  = '0;

  // Predictor state
  bit              sum_map [0:SUM_LIMIT_DEF];
  logic [5:0]      first_item_of_sum [0:SUM_LIMIT_DEF];
  logic [ValW-1:0] item_vals [0:MAX_ITEMS_DEF-1];
  int unsigned     item_count;
  logic [ValW-1:0] cap_reg;

  ssm_out_t        trace_words[$];    // words of the set just closed
  ssm_out_t        pending_words[$];  // expected result words, oldest first
  bit              failed = 1'b0;
  bit              quiet = 1'b0;      // no idling near the end
  int unsigned     words_checked = 0;

  subset_sum_max_with_selection u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Back to "only sum zero reachable", no items taken
  task automatic clear_sums();
    for (int s = 0; s <= SUM_LIMIT_DEF; s++) begin
      sum_map[s] = 1'b0;
      first_item_of_sum[s] = '0;
    end
    sum_map[0] = 1'b1;
    item_count = 0;
  endtask

  // Fold one item into the map; on the last item build the sum and trace words
  task automatic fold_item(input ssm_in_t w);
    int unsigned     bound, best, s, steps, idx, wv;
    logic [ValW-1:0] v;
    bit              stop;
    ssm_out_t        wd;
    trace_words.delete();
    v = w.item_value;
    bound = (cap_reg < SUM_LIMIT_DEF) ? cap_reg : SUM_LIMIT_DEF;
    if (item_count < MAX_ITEMS_DEF) begin
      idx = item_count;
      item_vals[idx] = v;
      item_count++;
      // downward scan keeps each item 0/1
      if (v != 0 && v <= bound) begin
        for (int l = int'(bound) - int'(v); l >= 0; l--) begin
          if (sum_map[l] && !sum_map[l + v]) begin
            sum_map[l + v] = 1'b1;
            first_item_of_sum[l + v] = idx[5:0];
          end
        end
      end
    end
    if (w.last_item) begin
      best = 0;
      for (int k = 0; k <= int'(bound); k++) if (sum_map[k]) best = k;
      wd.kind = KIND_SUM;
      wd.result_value = best[ValW-1:0];
      wd.last = (best == 0);
      trace_words.push_back(wd);
      // trace back from the best sum
      s = best;
      steps = 0;
      stop = 1'b0;
      while (s != 0 && steps < MAX_ITEMS_DEF && !stop) begin
        idx = first_item_of_sum[s];
        if (idx >= MAX_ITEMS_DEF) begin
          stop = 1'b1;
        end else begin
          wv = item_vals[idx];
          if (wv == 0 || wv > s) begin
            stop = 1'b1;
          end else begin
            s -= wv;
            steps++;
            wd.kind = KIND_INDEX;
            wd.result_value = ValW'(idx + 1);
            wd.last = 1'b0;
            trace_words.push_back(wd);
          end
        end
      end
      wd = trace_words.pop_back();
      wd.last = 1'b1;
      trace_words.push_back(wd);
      clear_sums();
    end
  endtask

  // Random valid-low burst ahead of an item
  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Offer one word, wait for the handshake, then queue what it should produce
  task automatic accept_item(input ssm_in_t w, input bit typed,
                             input logic [ValW-1:0] exp_sum,
                             input logic [ValW-1:0] exp_idx);
    ssm_out_t wd;
    sender_gap();
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    fold_item(w);
    if (typed) begin
      trace_words.delete();
      wd.kind = KIND_SUM;
      wd.result_value = exp_sum;
      wd.last = (exp_idx == 0);
      trace_words.push_back(wd);
      if (exp_idx != 0) begin
        wd.kind = KIND_INDEX;
        wd.result_value = exp_idx;
        wd.last = 1'b1;
        trace_words.push_back(wd);
      end
    end
    foreach (trace_words[k]) pending_words.push_back(trace_words[k]);
  endtask

  // Capacity write once the block has drained and gone quiet
  task automatic write_capacity(input logic [ValW-1:0] v);
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg = v;
  endtask

  // Item values: mostly small against capacity, some zero, full-scale or oversized
  function automatic logic [ValW-1:0] pick_item(input int unsigned cap);
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return ValW'($urandom_range(0, 1023));
      2: return ValW'(cap);
      default: return ValW'($urandom_range(1, cap / 4 + 1));
    endcase
  endfunction

  // Result receiver: random stall bursts and one long hold-off
  initial begin
    int unsigned idle_left;
    bit          held;
    idle_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (idle_left > 0) begin
        idle_left--;
        out_ready_i <= 1'b0;
      end else if (!held && words_checked >= HOLD_AFTER && in_valid_i &&
                   in_ready_o !== 1'b1 && out_valid_o === 1'b1) begin
        // hold off while the sender is waiting with a word
        held = 1'b1;
        idle_left = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        idle_left = $urandom_range(0, 5);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    ssm_out_t want;
    if (out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word kind %0d value %0d last %0d", $time,
                 out_word_o.kind, out_word_o.result_value, out_word_o.last);
        failed = 1'b1;
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (want.kind !== out_word_o.kind ||
            want.result_value !== out_word_o.result_value ||
            want.last !== out_word_o.last) begin
          $display("%0t: mismatch exp kind %0d value %0d last %0d, got kind %0d value %0d last %0d",
                   $time, want.kind, want.result_value, want.last,
                   out_word_o.kind, out_word_o.result_value, out_word_o.last);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: too long with no handshake on any port
  initial begin
    int unsigned stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i) ||
          cfg_we_i)
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Main sequence
  initial begin
    int unsigned counted, cap, len, r;
    ssm_in_t     w;
    row_t        row;
    clear_sums();
    cap_reg = CAP_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TABLE[i];
      if (row.op == ROW_CAP) begin
        write_capacity(row.value);
      end else begin
        w.item_value = row.value;
        w.last_item  = row.last;
        accept_item(w, row.typed, row.exp_sum, row.exp_idx);
      end
    end

    // random phases: a capacity, then a few sets under it
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r == 0)      cap = 0;
      else if (r == 1) cap = 1023;
      else if (r == 2) cap = $urandom_range(1, 15);
      else             cap = $urandom_range(16, 1023);
      write_capacity(ValW'(cap));
      repeat ($urandom_range(2, 5)) begin
        // now and then a set longer than the item store
        if ($urandom_range(0, 15) == 0)
          len = $urandom_range(MAX_ITEMS_DEF + 1, MAX_ITEMS_DEF + 6);
        else
          len = $urandom_range(1, 8);
        for (int i = 0; i < int'(len); i++) begin
          w.item_value = pick_item(cap);
          w.last_item  = (i == int'(len) - 1);
          accept_item(w, 1'b0, '0, '0);
          if (i < MAX_ITEMS_DEF) counted++;
          if (counted >= QUIET_AFTER) quiet = 1'b1;
        end
      end
    end

    // drain and let any stray words show up
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (!failed)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
